// ----- rtl/core/dcfsa_pkg.sv -----
package dcfsa_pkg;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_CHAR   = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NEXT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_VERDICT = 2'd0,
        KIND_STATUS  = 2'd1,
        KIND_PATH    = 2'd2
    } t_kind;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  character;
        logic        is_directory;
        logic        top_level;
        logic        name_last;
    } t_in_beat;

    typedef struct packed {
        t_kind       kind;
        logic        matched;
        logic [13:0] number;
        logic        status;
        logic [7:0]  path_char;
        logic        last;
    } t_out_beat;

    // APB register map, 8-byte stride
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [1:0] REG_PREFIX = 2'd0;
    localparam logic [1:0] REG_TAG    = 2'd1;
    localparam logic [1:0] REG_EXT    = 2'd2;

    localparam logic [31:0] PREFIX_RST = 32'd1178813526;
    localparam logic [39:0] TAG_RST    = 40'd301776262738;
    localparam logic [23:0] EXT_RST    = 24'd4281929;

    localparam logic [13:0] NUM_MAX       = 14'd9999;
    localparam logic [13:0] DIR_MIN       = 14'd100;
    localparam logic [13:0] SESSION_MAX   = 14'd999;
    localparam logic [13:0] SESSION_FIRST = 14'd100;
    localparam logic [11:0] SESSION_FIRST_BCD = 12'h100;

    localparam int          PATH_IDX_W = 5;
    localparam logic [4:0]  PATH_LAST  = 5'd26;

    localparam logic [47:0] PATH_HEAD = "/DCIM/";
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [7:0]  CH_DOT    = 8'h2E;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;

endpackage

// ----- rtl/core/dcf_name_scan_and_allocate_core.sv -----
// channel | handshake                    | payload
// --------+------------------------------+------------------------------
// in      | i_in_valid / o_in_ready      | i_in_data  (t_in_beat)
// out     | o_out_valid / i_out_ready    | o_out_data (t_out_beat)
// cfg     | psel, penable, pwrite, pready| paddr, pwdata, prdata (64 bit)
//
// Every command is handled in the cycle it is accepted and any result it gives
// lands in the output register, so one beat per cycle is taken while that
// register is free or being drained. A next-clip command holds the input while
// the path characters go out one per cycle from a 5-bit index counter.
// Reset is synchronous; no clearing pass is needed. Backpressure on the output
// stalls both the path stream and the input.
module dcf_name_scan_and_allocate_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dcfsa_pkg::t_in_beat           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dcfsa_pkg::t_out_beat          o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcfsa_pkg::ADDR_W-1:0]  paddr,
    input  logic [dcfsa_pkg::DATA_W-1:0]  pwdata,
    output logic [dcfsa_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import dcfsa_pkg::*;

    logic [31:0] r_prefix;
    logic [39:0] r_tag;
    logic [23:0] r_ext;

    // binary copies for compares, BCD copies for printing
    logic [13:0] r_hdir,    n_hdir;
    logic [15:0] r_hdir_bcd, n_hdir_bcd;
    logic [13:0] r_hidx,    n_hidx;
    logic [15:0] r_hidx_bcd, n_hidx_bcd;
    logic [13:0] r_sess,    n_sess;
    logic [11:0] r_sess_bcd, n_sess_bcd;
    logic [13:0] r_clip,    n_clip;
    logic [15:0] r_clip_bcd, n_clip_bcd;

    logic [3:0]  r_pos,  n_pos;
    logic [13:0] r_dv,   n_dv;
    logic [15:0] r_dv_bcd, n_dv_bcd;
    logic        r_ok,   n_ok;

    logic                  r_stream, n_stream;
    logic [PATH_IDX_W-1:0] r_idx,    n_idx;

    logic        r_ov, n_ov;
    t_out_beat   r_out, n_out;

    logic        w_slot_free;
    logic        w_accept;
    logic [7:0]  w_pc_stream;
    logic [7:0]  w_pc_first;

    function automatic logic [15:0] bcd_inc(input logic [15:0] v);
        logic [15:0] res;
        logic        carry;
        res   = v;
        carry = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (carry) begin
                if (v[4*k +: 4] == 4'd9) begin
                    res[4*k +: 4] = 4'd0;
                end else begin
                    res[4*k +: 4] = v[4*k +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] tag_char(input logic [39:0] t, input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = t[39:32];
            3'd1:    c = t[31:24];
            3'd2:    c = t[23:16];
            3'd3:    c = t[15:8];
            3'd4:    c = t[7:0];
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [31:0] p, input logic [1:0] i);
        return p[8*(3 - int'(i)) +: 8];
    endfunction

    function automatic logic [7:0] ext_char(input logic [23:0] e, input logic [1:0] i);
        logic [7:0] c;
        unique case (i)
            2'd0:    c = e[23:16];
            2'd1:    c = e[15:8];
            2'd2:    c = e[7:0];
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] head_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = PATH_HEAD[47:40];
            3'd1:    c = PATH_HEAD[39:32];
            3'd2:    c = PATH_HEAD[31:24];
            3'd3:    c = PATH_HEAD[23:16];
            3'd4:    c = PATH_HEAD[15:8];
            3'd5:    c = PATH_HEAD[7:0];
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // "/DCIM/" sss tag "/" prefix cccc "." ext
    function automatic logic [7:0] path_char_at(
        input logic [PATH_IDX_W-1:0] idx,
        input logic [11:0]           sess_bcd,
        input logic [15:0]           clip_bcd,
        input logic [39:0]           tag,
        input logic [31:0]           prefix,
        input logic [23:0]           ext
    );
        logic [7:0]            c;
        logic [PATH_IDX_W-1:0] off;
        c   = 8'd0;
        off = '0;
        priority if (idx < 5'd6) begin
            c = head_char(idx[2:0]);
        end else if (idx < 5'd9) begin
            off = idx - 5'd6;
            c   = {4'h3, sess_bcd[4*(2 - int'(off[1:0])) +: 4]};
        end else if (idx < 5'd14) begin
            off = idx - 5'd9;
            c   = tag_char(tag, off[2:0]);
        end else if (idx == 5'd14) begin
            c = CH_SLASH;
        end else if (idx < 5'd19) begin
            off = idx - 5'd15;
            c   = prefix_char(prefix, off[1:0]);
        end else if (idx < 5'd23) begin
            off = idx - 5'd19;
            c   = {4'h3, clip_bcd[4*(3 - int'(off[1:0])) +: 4]};
        end else if (idx == 5'd23) begin
            c = CH_DOT;
        end else begin
            off = idx - 5'd24;
            c   = ext_char(ext, off[1:0]);
        end
        return c;
    endfunction

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= PREFIX_RST;
            r_tag    <= TAG_RST;
            r_ext    <= EXT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:3])
                REG_PREFIX: r_prefix <= pwdata[31:0];
                REG_TAG:    r_tag    <= pwdata[39:0];
                REG_EXT:    r_ext    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_PREFIX: prdata = {32'd0, r_prefix};
            REG_TAG:    prdata = {24'd0, r_tag};
            REG_EXT:    prdata = {40'd0, r_ext};
            default:    prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    assign w_slot_free = !r_ov || i_out_ready;
    assign o_in_ready  = !r_stream && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_pc_stream = path_char_at(r_idx, r_sess_bcd, r_clip_bcd, r_tag, r_prefix, r_ext);
    assign w_pc_first  = path_char_at('0, r_sess_bcd, r_clip_bcd, r_tag, r_prefix, r_ext);

    always_comb begin
        logic        top;
        logic [7:0]  c;
        logic        num_char;
        logic        add;
        logic        fresh;
        logic [16:0] acc;
        logic        m;
        logic [15:0] inc;

        n_hdir     = r_hdir;
        n_hdir_bcd = r_hdir_bcd;
        n_hidx     = r_hidx;
        n_hidx_bcd = r_hidx_bcd;
        n_sess     = r_sess;
        n_sess_bcd = r_sess_bcd;
        n_clip     = r_clip;
        n_clip_bcd = r_clip_bcd;
        n_pos      = r_pos;
        n_dv       = r_dv;
        n_dv_bcd   = r_dv_bcd;
        n_ok       = r_ok;
        n_stream   = r_stream;
        n_idx      = r_idx;
        n_ov       = r_ov && !i_out_ready;
        n_out      = r_out;

        top      = i_in_data.top_level;
        c        = i_in_data.character;
        num_char = (c >= CH_ZERO) && (c <= CH_NINE);
        add      = 1'b0;
        fresh    = 1'b0;
        acc      = '0;
        m        = 1'b0;
        inc      = '0;

        if (r_stream && w_slot_free) begin
            n_ov            = 1'b1;
            n_out           = '0;
            n_out.kind      = KIND_PATH;
            n_out.path_char = w_pc_stream;
            n_out.last      = (r_idx == PATH_LAST);
            n_idx           = r_idx + 5'd1;
            if (r_idx == PATH_LAST) begin
                n_stream   = 1'b0;
                n_clip     = r_clip + 14'd1;
                n_clip_bcd = bcd_inc(r_clip_bcd);
            end
        end else if (w_accept) begin
            unique case (i_in_data.command)
                CMD_BEGIN: begin
                    n_hdir     = '0;
                    n_hdir_bcd = '0;
                    n_hidx     = '0;
                    n_hidx_bcd = '0;
                    n_pos      = '0;
                    n_dv       = '0;
                    n_dv_bcd   = '0;
                    n_ok       = 1'b1;
                end
                CMD_CHAR: begin
                    if (top) begin
                        if (r_pos < 4'd3) begin
                            add   = num_char;
                            fresh = (r_pos == 4'd0);
                            if (!num_char) n_ok = 1'b0;
                        end else if (r_pos < 4'd8) begin
                            if (c != tag_char(r_tag, 3'(r_pos - 4'd3))) n_ok = 1'b0;
                        end else begin
                            n_ok = 1'b0;
                        end
                    end else begin
                        if (r_pos < 4'd4) begin
                            if (c != prefix_char(r_prefix, r_pos[1:0])) n_ok = 1'b0;
                        end else if (r_pos < 4'd8) begin
                            add   = num_char;
                            fresh = (r_pos == 4'd4);
                            if (!num_char) n_ok = 1'b0;
                        end else if (r_pos == 4'd8) begin
                            if (c != CH_DOT) n_ok = 1'b0;
                        end else if (r_pos < 4'd12) begin
                            if (c != ext_char(r_ext, 2'(r_pos - 4'd9))) n_ok = 1'b0;
                        end else begin
                            n_ok = 1'b0;
                        end
                    end

                    if (add) begin
                        if (fresh) begin
                            n_dv     = {10'd0, c[3:0]};
                            n_dv_bcd = {12'd0, c[3:0]};
                        end else begin
                            acc = 17'({3'd0, r_dv} * 17'd10) + {13'd0, c[3:0]};
                            if (acc > {3'd0, NUM_MAX}) begin
                                n_ok     = 1'b0;
                                n_dv     = NUM_MAX;
                                n_dv_bcd = 16'h9999;
                            end else begin
                                n_dv     = acc[13:0];
                                n_dv_bcd = {r_dv_bcd[11:0], c[3:0]};
                            end
                        end
                    end

                    if (!i_in_data.name_last) begin
                        n_pos = (r_pos == 4'd15) ? 4'd15 : r_pos + 4'd1;
                    end else begin
                        if (top) begin
                            if (n_ok && r_pos == 4'd7 && i_in_data.is_directory
                                && n_dv >= DIR_MIN) begin
                                m = 1'b1;
                                if (n_dv > r_hdir) begin
                                    n_hdir     = n_dv;
                                    n_hdir_bcd = n_dv_bcd;
                                end
                            end
                        end else begin
                            if (n_ok && r_pos == 4'd11 && !i_in_data.is_directory) begin
                                m = 1'b1;
                                if (n_dv > r_hidx) begin
                                    n_hidx     = n_dv;
                                    n_hidx_bcd = n_dv_bcd;
                                end
                            end
                        end
                        n_ov          = 1'b1;
                        n_out         = '0;
                        n_out.kind    = KIND_VERDICT;
                        n_out.matched = m;
                        n_out.number  = m ? n_dv : 14'd0;
                        n_out.last    = 1'b1;
                        n_pos         = '0;
                        n_dv          = '0;
                        n_dv_bcd      = '0;
                        n_ok          = 1'b1;
                    end
                end
                CMD_FINISH: begin
                    if (r_hdir == '0) begin
                        n_sess     = SESSION_FIRST;
                        n_sess_bcd = SESSION_FIRST_BCD;
                    end else begin
                        n_sess     = r_hdir + 14'd1;
                        inc        = bcd_inc(r_hdir_bcd);
                        n_sess_bcd = inc[11:0];
                    end
                    n_clip       = r_hidx + 14'd1;
                    n_clip_bcd   = bcd_inc(r_hidx_bcd);
                    n_pos        = '0;
                    n_dv         = '0;
                    n_dv_bcd     = '0;
                    n_ok         = 1'b1;
                    n_ov         = 1'b1;
                    n_out        = '0;
                    n_out.kind   = KIND_STATUS;
                    n_out.status = (n_sess > SESSION_MAX);
                    n_out.last   = 1'b1;
                end
                CMD_NEXT: begin
                    n_ov  = 1'b1;
                    n_out = '0;
                    if (r_sess > SESSION_MAX || r_clip > NUM_MAX) begin
                        n_out.kind   = KIND_STATUS;
                        n_out.status = 1'b1;
                        n_out.last   = 1'b1;
                    end else begin
                        // first character goes out now, the rest stream from index 1
                        n_out.kind      = KIND_PATH;
                        n_out.path_char = w_pc_first;
                        n_stream        = 1'b1;
                        n_idx           = 5'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdir     <= '0;
            r_hdir_bcd <= '0;
            r_hidx     <= '0;
            r_hidx_bcd <= '0;
            r_sess     <= SESSION_FIRST;
            r_sess_bcd <= SESSION_FIRST_BCD;
            r_clip     <= 14'd1;
            r_clip_bcd <= 16'h0001;
            r_pos      <= '0;
            r_dv       <= '0;
            r_dv_bcd   <= '0;
            r_ok       <= 1'b1;
            r_stream   <= 1'b0;
            r_idx      <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_hdir     <= n_hdir;
            r_hdir_bcd <= n_hdir_bcd;
            r_hidx     <= n_hidx;
            r_hidx_bcd <= n_hidx_bcd;
            r_sess     <= n_sess;
            r_sess_bcd <= n_sess_bcd;
            r_clip     <= n_clip;
            r_clip_bcd <= n_clip_bcd;
            r_pos      <= n_pos;
            r_dv       <= n_dv;
            r_dv_bcd   <= n_dv_bcd;
            r_ok       <= n_ok;
            r_stream   <= n_stream;
            r_idx      <= n_idx;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule
